/* design/kpc_pkg.sv */
// package for the keyboard port controller: request and response types and constants
`timescale 1ns / 1ps

package kpc_pkg;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] port_address;
		logic [7:0]  write_data;
		logic [6:0]  scan_code;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_level;
	} rsp_t;

	localparam logic [2:0] OP_WRITE   = 3'd0;
	localparam logic [2:0] OP_READ    = 3'd1;
	localparam logic [2:0] OP_FRAME   = 3'd2;
	localparam logic [2:0] OP_PRESS   = 3'd3;
	localparam logic [2:0] OP_RELEASE = 3'd4;
	localparam logic [2:0] OP_TICK    = 3'd5;

	localparam logic [15:0] PORT_DATA = 16'h0060;
	localparam logic [15:0] PORT_CTRL = 16'h0061;

	localparam logic [7:0] CMD_KBD_RESET      = 8'hA1;
	localparam logic [7:0] CTRL_RESET_VALUE   = 8'h48;
	localparam logic [7:0] PRESS_FLAG         = 8'h80;
	localparam logic [7:0] SELFTEST_CODE      = 8'h2A;
	localparam logic [7:0] UNKNOWN_PORT_VALUE = 8'hFF;

	localparam logic [15:0] DELAY_RESET_VALUE = 16'd2000;

	localparam int QUEUE_DEPTH_DEFAULT = 8;

	// configuration register indexes
	localparam logic REG_RESET_DELAY = 1'b0;

endpackage

/* design/keyboard_port_controller_unit.sv */
// keyboard port controller: scan code fifo, data latch, control port and reset delay
//
//  channel  | valid      | stall      | payload           | notes
//  request  | req_valid  | req_stall  | req  (req_t)      | port access, key event or tick
//  response | rsp_valid  | rsp_stall  | rsp  (rsp_t)      | one per request, in order
//  config   | psel/penable/pwrite | pready=1 | paddr/pwdata/prdata | reset delay register
//
// one request per cycle while req_stall is low; its result is registered in the response
// register, or in a skid register that takes a second result while the response is stalled;
// the request side stalls only while that skid register is full.
// arst_n resets all control state: it clears the latch and loads the control byte and delay register.
`timescale 1ns / 1ps

module keyboard_port_controller_unit #(
	parameter int QUEUE_DEPTH = kpc_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  kpc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output kpc_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	// configuration
	logic [15:0] delay_cfg_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_cfg_q <= kpc_pkg::DELAY_RESET_VALUE;
		end else if (cfg_wr && paddr[2] == kpc_pkg::REG_RESET_DELAY) begin
			delay_cfg_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == kpc_pkg::REG_RESET_DELAY) ? {16'd0, delay_cfg_q} : 32'd0;

	// state
	logic [7:0]       queue_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       latch_q;
	logic             consumed_q;
	logic [7:0]       ctrl_q;
	logic [15:0]      delay_cnt_q;
	logic             delay_run_q;
	logic             irq_q;

	logic rsp_valid_q, skid_valid_q;
	kpc_pkg::rsp_t rsp_q, skid_q;

	logic acc, take;
	assign req_stall = skid_valid_q;
	assign acc       = req_valid && !skid_valid_q;
	assign take      = rsp_valid_q && !rsp_stall;

	// next-state logic for one request
	logic             push_a_req, push_b_req, do_a, do_b;
	logic [7:0]       byte_a, byte_b;
	logic [PTR_W-1:0] tail_a, tail_b;
	logic [CNT_W-1:0] cnt_a;
	logic             pop_en, q_clear;
	logic [PTR_W-1:0] n_head, n_tail;
	logic [CNT_W-1:0] n_count;
	logic             n_latch_clr, n_consumed, n_irq, n_run;
	logic [7:0]       n_ctrl;
	logic [15:0]      n_delay;
	logic [7:0]       rdata;

	always_comb begin
		push_a_req  = 1'b0;
		push_b_req  = 1'b0;
		byte_a      = kpc_pkg::SELFTEST_CODE | kpc_pkg::PRESS_FLAG;
		byte_b      = kpc_pkg::SELFTEST_CODE;
		pop_en      = 1'b0;
		q_clear     = 1'b0;
		n_latch_clr = 1'b0;
		n_consumed  = consumed_q;
		n_irq       = irq_q;
		n_run       = delay_run_q;
		n_ctrl      = ctrl_q;
		n_delay     = delay_cnt_q;
		rdata       = 8'd0;

		case (req.operation)
			kpc_pkg::OP_WRITE: begin
				if (req.port_address == kpc_pkg::PORT_CTRL) begin
					if (req.write_data == kpc_pkg::CMD_KBD_RESET) begin
						q_clear    = 1'b1;
						n_consumed = 1'b1;
						n_delay    = delay_cfg_q;
						n_run      = 1'b1;
					end
					n_ctrl = req.write_data;
				end
			end
			kpc_pkg::OP_READ: begin
				if (req.port_address == kpc_pkg::PORT_DATA) begin
					n_consumed  = 1'b1;
					n_irq       = 1'b0;
					rdata       = latch_q;
					n_latch_clr = 1'b1;
				end else if (req.port_address == kpc_pkg::PORT_CTRL) begin
					rdata = ctrl_q;
				end else begin
					rdata = kpc_pkg::UNKNOWN_PORT_VALUE;
				end
			end
			kpc_pkg::OP_FRAME: begin
				if (count_q != '0 && consumed_q) begin
					pop_en     = 1'b1;
					n_consumed = 1'b0;
					n_irq      = 1'b1;
				end
			end
			kpc_pkg::OP_PRESS: begin
				byte_a     = {1'b1, req.scan_code};
				push_a_req = req.scan_code != 7'd0;
			end
			kpc_pkg::OP_RELEASE: begin
				byte_a     = {1'b0, req.scan_code};
				push_a_req = req.scan_code != 7'd0;
			end
			kpc_pkg::OP_TICK: begin
				if (delay_run_q) begin
					if (delay_cnt_q <= 16'd1) begin
						n_delay    = 16'd0;
						n_run      = 1'b0;
						push_a_req = 1'b1;
						push_b_req = 1'b1;
					end else begin
						n_delay = delay_cnt_q - 16'd1;
					end
				end
			end
			default: begin
			end
		endcase

		// up to two pushes, each dropped when the fifo is full
		do_a   = push_a_req && (count_q < CNT_FULL);
		tail_a = do_a ? ptr_inc(tail_q) : tail_q;
		cnt_a  = count_q + CNT_W'(do_a);
		do_b   = push_b_req && (cnt_a < CNT_FULL);
		tail_b = do_b ? ptr_inc(tail_a) : tail_a;

		if (q_clear) begin
			n_head  = '0;
			n_tail  = '0;
			n_count = '0;
		end else begin
			n_head  = pop_en ? ptr_inc(head_q) : head_q;
			n_tail  = tail_b;
			n_count = cnt_a + CNT_W'(do_b) - CNT_W'(pop_en);
		end
	end

	// fifo storage; the pop reads straight into the data latch
	always_ff @(posedge clk) begin
		if (acc && do_a) begin
			queue_mem[tail_q] <= byte_a;
		end
		if (acc && do_b) begin
			queue_mem[tail_a] <= byte_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			latch_q     <= 8'd0;
			consumed_q  <= 1'b1;
			ctrl_q      <= kpc_pkg::CTRL_RESET_VALUE;
			delay_cnt_q <= 16'd0;
			delay_run_q <= 1'b0;
			irq_q       <= 1'b0;
		end else if (acc) begin
			head_q      <= n_head;
			tail_q      <= n_tail;
			count_q     <= n_count;
			consumed_q  <= n_consumed;
			ctrl_q      <= n_ctrl;
			delay_cnt_q <= n_delay;
			delay_run_q <= n_run;
			irq_q       <= n_irq;
			if (pop_en) begin
				latch_q <= queue_mem[head_q];
			end else if (n_latch_clr) begin
				latch_q <= 8'd0;
			end
		end
	end

	// response register and skid register
	kpc_pkg::rsp_t result;
	assign result.read_data = rdata;
	assign result.irq_level = n_irq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (rsp_valid_q && !take) begin
			if (acc) begin
				skid_valid_q <= 1'b1;
			end
		end else begin
			rsp_valid_q <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				rsp_q <= skid_q;
			end
		end else if (rsp_valid_q && !take) begin
			if (acc) begin
				skid_q <= result;
			end
		end else if (acc) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* test/keyboard_port_controller_unit_tb.sv */
// testbench for the keyboard port controller: directed rows, random requests, apb delay writes
`timescale 1ns / 1ps

module keyboard_port_controller_unit_tb;

	localparam logic [2:0] OP_UNUSED_6 = 3'd6;
	localparam logic [2:0] OP_UNUSED_7 = 3'd7;
	localparam int         FIFO_DEPTH  = kpc_pkg::QUEUE_DEPTH_DEFAULT;
	localparam int         SHOWN_MAX   = 10;

	typedef struct packed {
		logic          on;
		kpc_pkg::rsp_t value;
	} typed_reply_t;

	typedef struct packed {
		kpc_pkg::req_t rq;
		logic          fixed_on;
		kpc_pkg::rsp_t want;
	} dir_row_t;

	localparam int DIRECTED_ROWS = 25;
	localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{'{kpc_pkg::OP_READ, kpc_pkg::PORT_CTRL, 8'h00, 7'h00}, 1'b1,
			'{kpc_pkg::CTRL_RESET_VALUE, 1'b0}},
		'{'{kpc_pkg::OP_READ, kpc_pkg::PORT_DATA, 8'hFF, 7'h7F}, 1'b1, '{8'h00, 1'b0}},
		'{'{kpc_pkg::OP_READ, 16'hFFFF, 8'h00, 7'h00}, 1'b1,
			'{kpc_pkg::UNKNOWN_PORT_VALUE, 1'b0}},
		'{'{kpc_pkg::OP_READ, 16'h0000, 8'hFF, 7'h7F}, 1'b1,
			'{kpc_pkg::UNKNOWN_PORT_VALUE, 1'b0}},
		'{'{kpc_pkg::OP_FRAME, 16'hFFFF, 8'hFF, 7'h7F}, 1'b1, '{8'h00, 1'b0}},
		'{'{kpc_pkg::OP_PRESS, 16'hFFFF, 8'hFF, 7'h7F}, 1'b1, '{8'h00, 1'b0}},
		'{'{kpc_pkg::OP_RELEASE, 16'h0000, 8'h00, 7'h01}, 1'b1, '{8'h00, 1'b0}},
		'{'{kpc_pkg::OP_PRESS, kpc_pkg::PORT_CTRL, kpc_pkg::CMD_KBD_RESET, 7'h00}, 1'b1,
			'{8'h00, 1'b0}},
		'{'{kpc_pkg::OP_RELEASE, 16'hFFFF, 8'hFF, 7'h00}, 1'b1, '{8'h00, 1'b0}},
		'{'{kpc_pkg::OP_FRAME, 16'h0000, 8'h00, 7'h00}, 1'b0, '0},
		'{'{kpc_pkg::OP_FRAME, kpc_pkg::PORT_DATA, 8'h00, 7'h00}, 1'b0, '0},
		'{'{kpc_pkg::OP_READ, kpc_pkg::PORT_DATA, 8'h00, 7'h00}, 1'b1, '{8'hFF, 1'b0}},
		'{'{kpc_pkg::OP_READ, kpc_pkg::PORT_DATA, 8'h00, 7'h00}, 1'b1, '{8'h00, 1'b0}},
		'{'{kpc_pkg::OP_FRAME, 16'h0000, 8'h00, 7'h00}, 1'b0, '0},
		'{'{kpc_pkg::OP_WRITE, kpc_pkg::PORT_DATA, 8'h55, 7'h00}, 1'b0, '0},
		'{'{kpc_pkg::OP_WRITE, kpc_pkg::PORT_CTRL, 8'h00, 7'h00}, 1'b0, '0},
		'{'{kpc_pkg::OP_READ, kpc_pkg::PORT_CTRL, 8'h00, 7'h00}, 1'b0, '0},
		'{'{kpc_pkg::OP_WRITE, kpc_pkg::PORT_CTRL, 8'hFF, 7'h7F}, 1'b0, '0},
		'{'{kpc_pkg::OP_READ, kpc_pkg::PORT_CTRL, 8'h00, 7'h00}, 1'b1, '{8'hFF, 1'b1}},
		'{'{OP_UNUSED_6, kpc_pkg::PORT_CTRL, kpc_pkg::CMD_KBD_RESET, 7'h2A}, 1'b0, '0},
		'{'{OP_UNUSED_7, kpc_pkg::PORT_DATA, 8'hFF, 7'h7F}, 1'b0, '0},
		'{'{kpc_pkg::OP_WRITE, 16'hFFFF, kpc_pkg::CMD_KBD_RESET, 7'h00}, 1'b0, '0},
		'{'{kpc_pkg::OP_WRITE, kpc_pkg::PORT_CTRL, kpc_pkg::CMD_KBD_RESET, 7'h00}, 1'b0, '0},
		'{'{kpc_pkg::OP_TICK, 16'h0000, 8'h00, 7'h00}, 1'b0, '0},
		'{'{kpc_pkg::OP_READ, kpc_pkg::PORT_DATA, 8'h00, 7'h00}, 1'b0, '0}
	};

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	kpc_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	kpc_pkg::rsp_t rsp;
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [2:0]    paddr;
	logic [31:0]   pwdata;
	logic [31:0]   prdata;
	logic          pready;

	keyboard_port_controller_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req     (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the controller state
	logic [7:0]  scan_fifo[$];
	logic [7:0]  latch_byte     = 8'h00;
	logic        latch_read     = 1'b1;
	logic [7:0]  ctrl_byte      = kpc_pkg::CTRL_RESET_VALUE;
	logic [15:0] delay_left     = 16'd0;
	logic        delay_active   = 1'b0;
	logic        irq_line       = 1'b0;
	logic [15:0] delay_setting  = kpc_pkg::DELAY_RESET_VALUE;

	kpc_pkg::rsp_t pending_replies[$];
	typed_reply_t  typed_replies[$];

	int mismatches     = 0;
	int requests_taken = 0;
	int replies_seen   = 0;
	int codes_dropped  = 0;
	int selftest_pairs = 0;
	int latch_loads    = 0;
	int reset_cmds     = 0;
	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	int rsp_hold_left  = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic void push_code(logic [7:0] code);
		if (scan_fifo.size() < FIFO_DEPTH)
			scan_fifo.push_back(code);
		else
			codes_dropped++;
	endfunction

	function automatic kpc_pkg::rsp_t kbd_port_update(kpc_pkg::req_t r);
		kpc_pkg::rsp_t out;
		out = '0;
		case (r.operation)
			kpc_pkg::OP_WRITE: begin
				if (r.port_address == kpc_pkg::PORT_CTRL) begin
					if (r.write_data == kpc_pkg::CMD_KBD_RESET) begin
						scan_fifo.delete();
						latch_read   = 1'b1;
						delay_left   = delay_setting;
						delay_active = 1'b1;
						reset_cmds++;
					end
					ctrl_byte = r.write_data;
				end
			end
			kpc_pkg::OP_READ: begin
				if (r.port_address == kpc_pkg::PORT_DATA) begin
					latch_read    = 1'b1;
					irq_line      = 1'b0;
					out.read_data = latch_byte;
					latch_byte    = 8'h00;
				end else if (r.port_address == kpc_pkg::PORT_CTRL) begin
					out.read_data = ctrl_byte;
				end else begin
					out.read_data = kpc_pkg::UNKNOWN_PORT_VALUE;
				end
			end
			kpc_pkg::OP_FRAME: begin
				if (scan_fifo.size() > 0 && latch_read) begin
					latch_byte = scan_fifo.pop_front();
					latch_read = 1'b0;
					irq_line   = 1'b1;
					latch_loads++;
				end
			end
			kpc_pkg::OP_PRESS: begin
				if (r.scan_code != 7'd0)
					push_code({1'b0, r.scan_code} | kpc_pkg::PRESS_FLAG);
			end
			kpc_pkg::OP_RELEASE: begin
				if (r.scan_code != 7'd0)
					push_code({1'b0, r.scan_code});
			end
			kpc_pkg::OP_TICK: begin
				if (delay_active) begin
					// a zero setting expires on the first tick, like a setting of one
					if (delay_left <= 16'd1) begin
						delay_left   = 16'd0;
						delay_active = 1'b0;
						push_code(kpc_pkg::SELFTEST_CODE | kpc_pkg::PRESS_FLAG);
						push_code(kpc_pkg::SELFTEST_CODE);
						selftest_pairs++;
					end else begin
						delay_left = delay_left - 16'd1;
					end
				end
			end
			default: begin
			end
		endcase
		out.irq_level = irq_line;
		return out;
	endfunction

	always @(posedge clk) begin : reply_check
		kpc_pkg::rsp_t want;
		typed_reply_t  typed;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				want = kbd_port_update(req);
				typed = typed_replies.size() ? typed_replies.pop_front() : '0;
				if (typed.on)
					want = typed.value;
				pending_replies.push_back(want);
				requests_taken++;
			end
			if (rsp_valid && !rsp_stall) begin
				replies_seen++;
				if (pending_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOWN_MAX)
						$display("%t unexpected response: read_data %h irq %b",
							$realtime, rsp.read_data, rsp.irq_level);
				end else begin
					want = pending_replies.pop_front();
					if (rsp.read_data !== want.read_data || rsp.irq_level !== want.irq_level) begin
						mismatches++;
						if (mismatches <= SHOWN_MAX)
							$display("%t response %0d: read_data exp %h got %h, irq exp %b got %b",
								$realtime, replies_seen, want.read_data, rsp.read_data,
								want.irq_level, rsp.irq_level);
					end
				end
			end
		end
	end

	// response side back-pressure
	always @(negedge clk) begin
		if (rsp_hold_left > 0) begin
			rsp_stall <= 1'b1;
			rsp_hold_left = rsp_hold_left - 1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// called and returns at a falling edge; valid stays high after acceptance
	task automatic send_req(kpc_pkg::req_t r, logic fixed_on, kpc_pkg::rsp_t fixed_val);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		typed_replies.push_back({fixed_on, fixed_val});
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic check_delay_reg(logic [15:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {kpc_pkg::REG_RESET_DELAY, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {16'h0000, v}) begin
			mismatches++;
			if (mismatches <= SHOWN_MAX)
				$display("%t delay register read: exp %h got %h", $realtime, v, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_reset_delay(logic [15:0] v);
		wait_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {kpc_pkg::REG_RESET_DELAY, 2'b00};
		pwdata  <= {16'h0000, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		delay_setting = v;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		check_delay_reg(v);
	endtask

	function automatic kpc_pkg::req_t random_request(int mode);
		kpc_pkg::req_t r;
		int            pick;
		r.operation    = 3'($urandom);
		r.port_address = 16'($urandom);
		r.write_data   = 8'($urandom);
		r.scan_code    = 7'($urandom);
		pick = $urandom_range(0, 99);
		if (mode == 1 && pick < 60) begin
			// key storm with few frames, fills the fifo
			r.operation = pick[0] ? kpc_pkg::OP_PRESS : kpc_pkg::OP_RELEASE;
			return r;
		end
		if (mode == 2 && pick < 60) begin
			r.operation = (pick < 30) ? kpc_pkg::OP_FRAME : kpc_pkg::OP_READ;
			if (r.operation == kpc_pkg::OP_READ)
				r.port_address = kpc_pkg::PORT_DATA;
			return r;
		end
		pick = $urandom_range(0, 99);
		if (pick < 18) begin
			r.operation = kpc_pkg::OP_PRESS;
		end else if (pick < 32) begin
			r.operation = kpc_pkg::OP_RELEASE;
		end else if (pick < 47) begin
			r.operation = kpc_pkg::OP_FRAME;
		end else if (pick < 62) begin
			r.operation = kpc_pkg::OP_TICK;
		end else if (pick < 76) begin
			r.operation    = kpc_pkg::OP_READ;
			r.port_address = kpc_pkg::PORT_DATA;
		end else if (pick < 80) begin
			r.operation    = kpc_pkg::OP_READ;
			r.port_address = kpc_pkg::PORT_CTRL;
		end else if (pick < 83) begin
			r.operation = kpc_pkg::OP_READ;
		end else if (pick < 88) begin
			r.operation    = kpc_pkg::OP_WRITE;
			r.port_address = kpc_pkg::PORT_CTRL;
			r.write_data   = kpc_pkg::CMD_KBD_RESET;
		end else if (pick < 92) begin
			r.operation    = kpc_pkg::OP_WRITE;
			r.port_address = kpc_pkg::PORT_CTRL;
		end else if (pick < 95) begin
			r.operation = kpc_pkg::OP_WRITE;
			if (pick[0])
				r.port_address = kpc_pkg::PORT_DATA;
		end else if (pick < 97) begin
			r.operation = pick[0] ? OP_UNUSED_7 : OP_UNUSED_6;
		end
		return r;
	endfunction

	task automatic run_random(int count);
		int mode;
		mode = 0;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				mode = $urandom_range(0, 2);
			send_req(random_request(mode), 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		check_delay_reg(kpc_pkg::DELAY_RESET_VALUE);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_req(DIRECTED[i].rq, DIRECTED[i].fixed_on, DIRECTED[i].want);

		send_idle_pct = 9;
		recv_idle_pct = 50;
		set_reset_delay(16'd1);
		run_random(600);

		send_idle_pct = 50;
		recv_idle_pct = 9;
		set_reset_delay(16'd0);
		run_random(600);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_reset_delay(16'hFFFF);
		run_random(120);

		set_reset_delay(16'd7);
		run_random(150);
		// long receiver hold while requests keep coming
		req_valid <= 1'b0;
		@(posedge clk);
		rsp_hold_left = 48;
		@(negedge clk);
		run_random(80);
		wait_drained();
		run_random(300);

		req_valid <= 1'b0;
		for (int i = 0; i < 5000 && pending_replies.size() != 0; i++)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (pending_replies.size() != 0) begin
			mismatches++;
			$display("%0d responses never arrived", pending_replies.size());
		end
		$display("%0d requests and %0d responses; %0d latch loads, %0d keyboard resets",
			requests_taken, replies_seen, latch_loads, reset_cmds);
		$display("%0d self-test pairs queued, %0d codes dropped on a full fifo",
			selftest_pairs, codes_dropped);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* files.f */
design/kpc_pkg.sv
design/keyboard_port_controller_unit.sv
test/keyboard_port_controller_unit_tb.sv
